/* rtl/lkvt_pkg.sv */
// ----------------------------------------------------------------------------
// lkvt_pkg: shared definitions for the linear key-value table
// Default sizes, request kinds, status codes and the control / status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkvt_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 32;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 6;

  // request kinds (code 3 behaves as a lookup)
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ABSENT    = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic start;     // capture the request, restart the scan
    logic scan_en;   // one scan step
    logic rd_last;   // read the last occupied slot
    logic wr_ins;    // append entry at the end
    logic wr_del;    // move last entry into the hit slot
    logic out_load;  // load the result register
  } lkvt_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_hit;   // key matched in this scan step
    logic scan_miss;  // scan ran past the occupied slots
    logic is_insert;
    logic is_delete;
    logic tbl_full;
  } lkvt_sts_t;

endpackage

/* rtl/lkvt_ram.sv */
// ----------------------------------------------------------------------------
// lkvt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lkvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lkvt_ctrl.sv */
// ----------------------------------------------------------------------------
// lkvt_ctrl: request sequencer
// Accepts one item, steps the scan, issues the update and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module lkvt_ctrl
  import lkvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  output lkvt_cmd_t cmd_o,
  input  lkvt_sts_t sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DWR  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0] state_q, state_d;
  logic       mvalid_q, mvalid_d;
  logic       out_free;

  assign out_free = !mvalid_q || m_tready_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = sts_i.is_delete ? S_DRD : S_RESP;
        end else if (sts_i.scan_miss) begin
          state_d = (sts_i.is_insert && !sts_i.tbl_full) ? S_INS : S_RESP;
        end
      end
      S_INS: begin
        cmd_o.wr_ins = 1'b1;
        state_d      = S_RESP;
      end
      S_DRD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_DWR;
      end
      S_DWR: begin
        cmd_o.wr_del = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    mvalid_d = mvalid_q;
    if (cmd_o.out_load) begin
      mvalid_d = 1'b1;
    end else if (m_tready_i) begin
      mvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = mvalid_q;

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mvalid_q && !m_tready_i |=> mvalid_q)
    else $error("result dropped while stalled");

  // an accepted item always starts a scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> state_q == S_SCAN)
    else $error("accepted item did not start a scan");

endmodule

/* rtl/lkvt_dp.sv */
// ----------------------------------------------------------------------------
// lkvt_dp: table datapath
// Key and value stores, occupancy count, scan pointer, compare and the
// result register.
// ----------------------------------------------------------------------------
module lkvt_dp
  import lkvt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int RES_W = 1 + VALUE_BITS + STATUS_W + COUNT_OUT_W + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  lkvt_cmd_t             cmd_i,
  output lkvt_sts_t             sts_o,
  output logic [RES_W-1:0]      res_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // request registers
  logic [KIND_W-1:0]     kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // scan state
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]      cmp_idx_q;
  logic                  hit_q, ins_ok_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [VALUE_BITS-1:0] hit_val_q;
  logic [RES_W-1:0]      res_q;

  // store ports
  logic                  issue, match;
  logic                  is_ins, is_del;
  logic [IDX_W-1:0]      last_idx, rd_addr, wr_addr;
  logic                  rd_en, wr_en;
  logic [KEY_BITS-1:0]   key_rdata, key_wdata;
  logic [VALUE_BITS-1:0] val_rdata, val_wdata;

  assign is_ins = (kind_q == KIND_INSERT);
  assign is_del = (kind_q == KIND_DELETE);

  // scan step: issue one read, compare the previous one
  assign issue    = ptr_q < count_q;
  assign match    = cmp_vld_q && (key_rdata == key_q);
  assign last_idx = IDX_W'(count_q - CNT_ONE);

  assign rd_en   = cmd_i.scan_en || cmd_i.rd_last;
  assign rd_addr = cmd_i.rd_last ? last_idx : ptr_q[IDX_W-1:0];

  // insert appends at the end, delete refills the hit slot
  assign wr_en     = cmd_i.wr_ins || cmd_i.wr_del;
  assign wr_addr   = cmd_i.wr_ins ? count_q[IDX_W-1:0] : hit_idx_q;
  assign key_wdata = cmd_i.wr_ins ? key_q : key_rdata;
  assign val_wdata = cmd_i.wr_ins ? value_q : val_rdata;

  lkvt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (key_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  lkvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  // pointer and count next values
  always_comb begin
    ptr_d     = ptr_q;
    cmp_vld_d = cmp_vld_q;
    count_d   = count_q;
    if (cmd_i.start) begin
      ptr_d     = '0;
      cmp_vld_d = 1'b0;
    end else if (cmd_i.scan_en) begin
      ptr_d     = issue ? ptr_q + CNT_ONE : ptr_q;
      cmp_vld_d = issue;
    end
    if (cmd_i.wr_ins) begin
      count_d = count_q + CNT_ONE;
    end else if (cmd_i.wr_del) begin
      count_d = count_q - CNT_ONE;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      ins_ok_q  <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      cmp_vld_q <= cmp_vld_d;
      if (cmd_i.start) begin
        hit_q    <= 1'b0;
        ins_ok_q <= 1'b0;
      end else begin
        if (cmd_i.scan_en && match) hit_q <= 1'b1;
        if (cmd_i.wr_ins) ins_ok_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (cmd_i.scan_en) begin
      cmp_idx_q <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.scan_en && match) begin
      hit_idx_q <= cmp_idx_q;
      hit_val_q <= val_rdata;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    logic [STATUS_W-1:0]   stat;
    logic [VALUE_BITS-1:0] rval;
    if (cmd_i.out_load) begin
      rval = '0;
      if (is_ins) begin
        stat = hit_q ? STAT_DUPLICATE : (ins_ok_q ? STAT_DONE : STAT_FULL);
      end else begin
        stat = hit_q ? STAT_DONE : STAT_ABSENT;
        if (!is_del && hit_q) rval = hit_val_q;
      end
      res_q <= {(count_q == '0), (count_q == CAP_CNT), COUNT_OUT_W'(count_q),
                stat, rval, hit_q};
    end
  end

  assign res_o = res_q;

  assign sts_o.scan_hit  = cmd_i.scan_en && match;
  assign sts_o.scan_miss = cmd_i.scan_en && !cmp_vld_q && !issue;
  assign sts_o.is_insert = is_ins;
  assign sts_o.is_delete = is_del;
  assign sts_o.tbl_full  = (count_q == CAP_CNT);

  // occupancy stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  // appends only into a table with room
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_ins |-> (count_q < CAP_CNT) && !hit_q)
    else $error("insert into full table or over a present key");

  // a delete moves an entry only after a hit in a non-empty table
  a_del_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_del |-> hit_q && (count_q != '0) && $past(cmd_i.rd_last))
    else $error("delete without hit or last-slot read");

endmodule

/* rtl/linear_key_value_table.sv */
// ----------------------------------------------------------------------------
// linear_key_value_table: unsorted key-value table with linear search
// Lookup, insert and delete requests over packed slots; one result per item.
// ----------------------------------------------------------------------------
// Scan: the key scan reads one stored key per cycle.
// Items: one at a time, the next taken the cycle after the result is loaded.
// Reset: asynchronous, active low; the table is empty, no result pending.
// ----------------------------------------------------------------------------
module linear_key_value_table
  import lkvt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int RES_W = 1 + VALUE_BITS + STATUS_W + COUNT_OUT_W + 2,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,  // key, new_value, zero pad
  input  logic [KIND_W-1:0] s_axis_tuser,  // kind
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata   // found, read_value, status,
                                           // entry_count, is_full, is_empty,
                                           // zero pad
);

  lkvt_cmd_t        cmd;
  lkvt_sts_t        sts;
  logic [RES_W-1:0] res;

  lkvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lkvt_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .kind_i  (s_axis_tuser),
    .key_i   (s_axis_tdata[KEY_BITS-1:0]),
    .value_i (s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .res_o   (res)
  );

  assign m_axis_tdata = OUT_W'(res);

endmodule

/* test/tb_linear_key_value_table.sv */
// ----------------------------------------------------------------------------
// tb_linear_key_value_table: self-checking testbench for the key-value table
// Drives lookup, insert, delete and spare-kind requests, keeps its own copy of
// the table to predict each result and compares every result field by field.
// Both stream sides idle and stall at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_key_value_table;
  import lkvt_pkg::*;

  localparam int CAP      = CAPACITY_DEF;
  localparam int KEY_W    = KEY_BITS_DEF;
  localparam int VAL_W    = VALUE_BITS_DEF;
  localparam int IN_W     = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int RES_W    = 1 + VAL_W + STATUS_W + COUNT_OUT_W + 2;
  localparam int OUT_W    = ((RES_W + 7) / 8) * 8;
  localparam int POOL_N   = 48;
  localparam int N_ITEMS  = 700;
  localparam int DRAIN    = 60;
  localparam int LIMIT    = 400000;

  // spare kind code, treated as a lookup
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    int unsigned       gap;
  } request_t;

  typedef struct {
    logic                   found;
    logic [VAL_W-1:0]       read_value;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_full;
    logic                   is_empty;
  } answer_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // key, new_value, zero pad
  logic [KIND_W-1:0] s_axis_tuser;   // kind
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;   // found, read_value, status, entry_count,
                                     // is_full, is_empty, zero pad

  linear_key_value_table i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow table
  logic [KEY_W-1:0] shadow_keys [CAP];
  logic [VAL_W-1:0] shadow_vals [CAP];
  int               shadow_count;

  request_t    request_q[$];
  answer_t     answer_q[$];
  logic [KEY_W-1:0] key_pool[POOL_N];
  bit          quiet_sender;
  int          err_cnt;
  int          accepted_cnt;
  int          result_cnt;
  int          kind_cnt[4];
  int          full_refusals;
  int          dup_inserts;
  int          peak_count;
  int          cycle_cnt;

  // predicts one result and updates the shadow table
  function automatic answer_t table_apply(request_t req);
    answer_t ans;
    int      slot;
    bit      hit;
    slot = 0;
    while (slot < shadow_count && shadow_keys[slot] != req.key) slot++;
    hit = (slot < shadow_count);
    ans.found      = hit;
    ans.read_value = '0;
    case (req.kind)
      KIND_INSERT: begin
        if (hit) begin
          ans.status = STAT_DUPLICATE;
          dup_inserts++;
        end else if (shadow_count >= CAP) begin
          ans.status = STAT_FULL;
          full_refusals++;
        end else begin
          shadow_keys[shadow_count] = req.key;
          shadow_vals[shadow_count] = req.value;
          shadow_count++;
          ans.status = STAT_DONE;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          shadow_keys[slot] = shadow_keys[shadow_count-1];
          shadow_vals[slot] = shadow_vals[shadow_count-1];
          shadow_count--;
          ans.status = STAT_DONE;
        end else begin
          ans.status = STAT_ABSENT;
        end
      end
      default: begin
        if (hit) begin
          ans.read_value = shadow_vals[slot];
          ans.status     = STAT_DONE;
        end else begin
          ans.status = STAT_ABSENT;
        end
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    ans.entry_count = shadow_count[COUNT_OUT_W-1:0];
    ans.is_full     = (shadow_count == CAP);
    ans.is_empty    = (shadow_count == 0);
    return ans;
  endfunction

  task automatic add_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                             logic [VAL_W-1:0] value);
    request_t req;
    req.kind  = kind;
    req.key   = key;
    req.value = value;
    req.gap   = quiet_sender ? 0 : $urandom_range(0, 9);
    request_q.push_back(req);
  endtask

  task automatic check_field(string name, longint unsigned exp_v,
                             longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
               $time, result_cnt, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // request driver
  request_t    on_bus;
  request_t    staged;
  bit          staged_ok;
  int unsigned wait_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      staged_ok     = 1'b0;
      wait_left     = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        answer_q.push_back(table_apply(on_bus));
        kind_cnt[on_bus.kind]++;
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!staged_ok && request_q.size() > 0) begin
          staged    = request_q.pop_front();
          wait_left = staged.gap;
          staged_ok = 1'b1;
        end
        if (staged_ok && wait_left == 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {staged.value, staged.key};
          s_axis_tuser  <= staged.kind;
          on_bus        = staged;
          staged_ok     = 1'b0;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (staged_ok) wait_left--;
        end
      end
    end
  end

  // result monitor with random back-pressure
  int unsigned stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result, actual %0h", $time, m_axis_tdata);
          err_cnt++;
        end else begin
          exp_a = answer_q.pop_front();
          check_field("found", exp_a.found, m_axis_tdata[0]);
          check_field("read_value", exp_a.read_value, m_axis_tdata[VAL_W:1]);
          check_field("status", exp_a.status, m_axis_tdata[VAL_W+2:VAL_W+1]);
          check_field("entry_count", exp_a.entry_count,
                      m_axis_tdata[VAL_W+2+COUNT_OUT_W:VAL_W+3]);
          check_field("is_full", exp_a.is_full, m_axis_tdata[VAL_W+3+COUNT_OUT_W]);
          check_field("is_empty", exp_a.is_empty, m_axis_tdata[VAL_W+4+COUNT_OUT_W]);
        end
        result_cnt++;
        // every fourth block of 50 results runs without stalls
        stall_left = ((result_cnt / 50) % 4 == 3) ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, answer_q.size());
      $display("tb_linear_key_value_table: FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    bit          taken[logic [KEY_W-1:0]];
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    logic [KIND_W-1:0] kd;
    int          phase;
    int          pick;
    int          n;

    rst_ni       = 1'b0;
    err_cnt      = 0;
    accepted_cnt = 0;
    result_cnt   = 0;
    kind_cnt     = '{default: 0};
    full_refusals = 0;
    dup_inserts  = 0;
    peak_count   = 0;
    cycle_cnt    = 0;
    shadow_count = 0;
    quiet_sender = 1'b0;

    // distinct key pool, extremes included
    key_pool[0] = '0;
    key_pool[1] = '1;
    taken[key_pool[0]] = 1'b1;
    taken[key_pool[1]] = 1'b1;
    for (int i = 2; i < POOL_N; i++) begin
      do k = KEY_W'($urandom_range(0, 2**KEY_W - 1)); while (taken.exists(k));
      taken[k]    = 1'b1;
      key_pool[i] = k;
    end

    // directed: empty table, extremes, duplicates, moves on delete, spare kind
    add_request(KIND_LOOKUP, 16'h0000, 32'h0);
    add_request(KIND_DELETE, 16'hffff, 32'h1);
    add_request(KIND_SPARE,  16'h0005, 32'h0);
    add_request(KIND_INSERT, 16'h0000, 32'h0000_0000);
    add_request(KIND_INSERT, 16'hffff, 32'hffff_ffff);
    add_request(KIND_INSERT, 16'h0000, 32'h1234_5678);
    add_request(KIND_LOOKUP, 16'h0000, 32'hdead_beef);
    add_request(KIND_LOOKUP, 16'hffff, 32'h0);
    add_request(KIND_SPARE,  16'hffff, 32'h0);
    add_request(KIND_LOOKUP, 16'h1234, 32'h0);
    add_request(KIND_INSERT, 16'h1234, 32'ha5a5_a5a5);
    add_request(KIND_DELETE, 16'h0000, 32'hffff_ffff);
    add_request(KIND_LOOKUP, 16'h1234, 32'h0);
    add_request(KIND_DELETE, 16'hffff, 32'h0);
    add_request(KIND_DELETE, 16'h1234, 32'h0);
    add_request(KIND_DELETE, 16'h1234, 32'h0);
    add_request(KIND_LOOKUP, 16'hffff, 32'h0);

    // fill to capacity, then refused and duplicate inserts on a full table
    for (int i = 0; i < CAP + 3; i++) add_request(KIND_INSERT, key_pool[i], $urandom());
    add_request(KIND_INSERT, key_pool[3], $urandom());
    add_request(KIND_LOOKUP, key_pool[CAP-1], 32'h0);
    add_request(KIND_DELETE, key_pool[0], 32'h0);
    add_request(KIND_INSERT, key_pool[CAP+1], 32'hffff_ffff);

    // random phases: fill-heavy, drain-heavy or mixed
    phase = 0;
    while (request_q.size() < N_ITEMS) begin
      quiet_sender = (phase % 4 == 3);
      n = $urandom_range(0, 2);
      for (int i = 0; i < 40; i++) begin
        pick = $urandom_range(0, 99);
        case (n)
          0:       kd = (pick < 75) ? KIND_INSERT : (pick < 88) ? KIND_LOOKUP :
                        (pick < 96) ? KIND_DELETE : KIND_SPARE;
          1:       kd = (pick < 65) ? KIND_DELETE : (pick < 82) ? KIND_LOOKUP :
                        (pick < 96) ? KIND_INSERT : KIND_SPARE;
          default: kd = (pick < 30) ? KIND_INSERT : (pick < 60) ? KIND_LOOKUP :
                        (pick < 90) ? KIND_DELETE : KIND_SPARE;
        endcase
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N-1)]
                                         : KEY_W'($urandom_range(0, 2**KEY_W - 1));
        pick = $urandom_range(0, 19);
        v = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
        add_request(kd, k, v);
      end
      phase++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (request_q.size() == 0 && !staged_ok && !s_axis_tvalid);
    wait (answer_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);

    $display("Requests: %0d (lookup %0d, insert %0d, delete %0d, spare kind %0d)",
             accepted_cnt, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3]);
    $display("Results: %0d, peak occupancy %0d, refused when full %0d, duplicates %0d",
             result_cnt, peak_count, full_refusals, dup_inserts);
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("tb_linear_key_value_table: PASS");
    end else begin
      $display("tb_linear_key_value_table: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lkvt_pkg.sv
rtl/lkvt_ram.sv
rtl/lkvt_ctrl.sv
rtl/lkvt_dp.sv
rtl/linear_key_value_table.sv
test/tb_linear_key_value_table.sv
